// ===== sv/gssim_pkg.sv =====
package gssim_pkg;

    localparam int unsigned CFG_W  = 9;
    localparam int unsigned PIX_W  = 8;
    localparam int unsigned SIM_W  = 17;
    localparam int unsigned MEAN_W = 16;
    localparam int unsigned DVD_W  = 64;
    localparam int unsigned DVS_W  = 48;
    localparam int unsigned MUL_W  = 32;
    localparam int unsigned VAR_W  = 40;
    localparam int unsigned NUM_W  = 34;

    localparam int unsigned DEF_MAX_WIDTH  = 256;
    localparam int unsigned DEF_MAX_HEIGHT = 256;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;
    localparam logic [0:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_IDX_HEIGHT = 1'b1;

    // 6.5025 and 58.5225 in Q16.16, rounded to nearest
    localparam logic [DVS_W-1:0] SSIM_C1 = 48'd426148;
    localparam logic [DVS_W-1:0] SSIM_C2 = 48'd3835331;
    localparam logic [NUM_W-1:0] NUM_SAT = 34'h1_FFFF_FFFF;
    localparam logic [MUL_W-1:0] R_MAX   = 32'h8000_0000;
    localparam logic [SIM_W-1:0] ONE_Q16 = 17'h10000;

    typedef enum logic [3:0] {
        S_LOAD, S_DIV, S_RD, S_DEV, S_SQX, S_SQY, S_XY, S_ACC,
        S_A, S_B1, S_B2, S_B3, S_PROD, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        D_MX, D_MY, D_SX, D_SY, D_SXY, D_R1, D_R2
    } t_div_op;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== sv/global_ssim_image_similarity_top.sv =====
// Channel     | Dir | Handshake                  | Payload
// s_axis      | in  | i_s_axis_tvalid/o_..tready | pixel_first[7:0], pixel_second[15:8]
// m_axis      | out | o_m_axis_tvalid/i_..tready | similarity[16:0], zero pad to 24
// cfg         | in  | i_cfg_wr_en                | index 0 image_width, 1 image_height
//
// Pixels load at one transaction per cycle into the pixel store.
// The last pixel of a frame starts the compute, paced by the shared divider
// (seven divisions) and by the single shared multiplier, which visits each stored
// pixel in turn. s_axis is not ready during the compute.
// Reset (synchronous, active low) clears the sums, count and sequencer.
// The result register frees the sequencer; a second result waits if m_axis stalls.
module global_ssim_image_similarity_top #(
    parameter int unsigned MAX_WIDTH  = gssim_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = gssim_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [15:0]                 i_s_axis_tdata,  // pixel_first, pixel_second
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [23:0]                 o_m_axis_tdata,  // similarity, pad
    input  logic                        i_cfg_wr_en,
    input  logic [0:0]                  i_cfg_index,
    input  logic [gssim_pkg::CFG_W-1:0] i_cfg_data
);
    import gssim_pkg::*;

    localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
    localparam int unsigned SUM_W  = PIX_W + ADDR_W;
    localparam int unsigned ACC_W  = 2 * MEAN_W + ADDR_W;
    localparam int unsigned WD_W   = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HT_W   = $clog2(MAX_HEIGHT + 1);

    t_state  r_state, n_state;
    t_div_op r_div_op, n_div_op;

    logic [CFG_W-1:0]  r_width, r_height;
    logic [CNT_W-1:0]  r_count, n_count, r_n, n_n;
    logic [SUM_W-1:0]  r_sum_x, n_sum_x, r_sum_y, n_sum_y;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [MEAN_W-1:0] r_mx, n_mx, r_my, n_my, r_ax, n_ax, r_ay, n_ay;
    logic [ACC_W-1:0]  r_acc_x, n_acc_x, r_acc_y, n_acc_y, r_acc_xy, n_acc_xy;
    logic [VAR_W-1:0]  r_sx, n_sx, r_sy, n_sy, r_sxy, n_sxy;
    logic [NUM_W-1:0]  r_a, n_a, r_c, n_c;
    logic [DVS_W-1:0]  r_b, n_b, r_d, n_d;
    logic [MUL_W-1:0]  r_r1, n_r1, r_r2, n_r2;
    logic              r_out_valid, n_out_valid;
    logic [SIM_W-1:0]  r_out_data, n_out_data;

    logic [31:0]        w_wd32, w_ht32;
    logic [WD_W-1:0]    w_wd;
    logic [HT_W-1:0]    w_ht;
    logic [CNT_W-1:0]   w_frame, w_cnt_inc;
    logic               w_accept, w_frame_end;
    logic               w_div_start, w_rd_en;
    logic [MUL_W-1:0]   w_mul_a, w_mul_b;
    logic [2*MUL_W-1:0] w_prod;
    logic [15:0]        w_rd_data, w_px, w_py;
    logic [NUM_W:0]     w_a_full;
    logic [VAR_W+1:0]   w_c_full, w_d_full;
    logic [DVD_W-1:0]   w_q;
    logic [19:0]        w_s;
    t_div_req           w_div_req;
    t_div_rsp           w_div_rsp;

    // clamped frame size
    always_comb begin
        w_wd32 = 32'(r_width);
        w_ht32 = 32'(r_height);
        if (w_wd32 < 32'd2)        w_wd32 = 32'd2;
        if (w_wd32 > MAX_WIDTH)    w_wd32 = MAX_WIDTH;
        if (w_ht32 < 32'd1)        w_ht32 = 32'd1;
        if (w_ht32 > MAX_HEIGHT)   w_ht32 = MAX_HEIGHT;
        w_wd    = WD_W'(w_wd32);
        w_ht    = HT_W'(w_ht32);
        w_frame = CNT_W'(w_wd * w_ht);
    end

    assign o_s_axis_tready = (r_state == S_LOAD);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cnt_inc       = r_count + 1'b1;
    assign w_frame_end     = w_cnt_inc >= w_frame;

    assign w_px     = {w_rd_data[15:8], 8'd0};
    assign w_py     = {w_rd_data[7:0], 8'd0};
    assign w_q      = w_div_rsp.quotient;
    assign w_a_full = (NUM_W+1)'({w_prod[MUL_W:0], 1'b0}) + (NUM_W+1)'(SSIM_C1);
    assign w_c_full = (VAR_W+2)'({r_sxy, 1'b0}) + (VAR_W+2)'(SSIM_C2);
    assign w_d_full = (VAR_W+2)'(r_sx) + (VAR_W+2)'(r_sy) + (VAR_W+2)'(SSIM_C2);
    assign w_s      = w_prod[63:44];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_RESET;
            r_height <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_IDX_WIDTH:  r_width  <= i_cfg_data;
                CFG_IDX_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_div_op    <= D_MX;
            r_count     <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_op    <= n_div_op;
            r_count     <= n_count;
            r_sum_x     <= n_sum_x;
            r_sum_y     <= n_sum_y;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_idx      <= n_idx;
        r_mx       <= n_mx;
        r_my       <= n_my;
        r_ax       <= n_ax;
        r_ay       <= n_ay;
        r_acc_x    <= n_acc_x;
        r_acc_y    <= n_acc_y;
        r_acc_xy   <= n_acc_xy;
        r_sx       <= n_sx;
        r_sy       <= n_sy;
        r_sxy      <= n_sxy;
        r_a        <= n_a;
        r_b        <= n_b;
        r_c        <= n_c;
        r_d        <= n_d;
        r_r1       <= n_r1;
        r_r2       <= n_r2;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_div_op    = r_div_op;
        n_count     = r_count;
        n_n         = r_n;
        n_sum_x     = r_sum_x;
        n_sum_y     = r_sum_y;
        n_idx       = r_idx;
        n_mx        = r_mx;
        n_my        = r_my;
        n_ax        = r_ax;
        n_ay        = r_ay;
        n_acc_x     = r_acc_x;
        n_acc_y     = r_acc_y;
        n_acc_xy    = r_acc_xy;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_sxy       = r_sxy;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_d         = r_d;
        n_r1        = r_r1;
        n_r2        = r_r2;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        w_div_start = 1'b0;
        w_rd_en     = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;

        case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    n_sum_x = r_sum_x + SUM_W'(i_s_axis_tdata[7:0]);
                    n_sum_y = r_sum_y + SUM_W'(i_s_axis_tdata[15:8]);
                    n_count = w_cnt_inc;
                    if (w_frame_end) begin
                        n_n         = w_cnt_inc;
                        n_div_op    = D_MX;
                        w_div_start = 1'b1;
                        n_state     = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    case (r_div_op)
                        D_MX: begin
                            n_mx        = w_q[MEAN_W-1:0];
                            n_div_op    = D_MY;
                            w_div_start = 1'b1;
                        end
                        D_MY: begin
                            n_my     = w_q[MEAN_W-1:0];
                            n_idx    = '0;
                            n_acc_x  = '0;
                            n_acc_y  = '0;
                            n_acc_xy = '0;
                            n_state  = S_RD;
                        end
                        D_SX: begin
                            n_sx        = w_q[VAR_W-1:0];
                            n_div_op    = D_SY;
                            w_div_start = 1'b1;
                        end
                        D_SY: begin
                            n_sy        = w_q[VAR_W-1:0];
                            n_div_op    = D_SXY;
                            w_div_start = 1'b1;
                        end
                        D_SXY: begin
                            n_sxy   = w_q[VAR_W-1:0];
                            n_state = S_A;
                        end
                        D_R1: begin
                            n_r1        = (w_q > DVD_W'(R_MAX)) ? R_MAX : w_q[MUL_W-1:0];
                            n_div_op    = D_R2;
                            w_div_start = 1'b1;
                        end
                        D_R2: begin
                            n_r2    = (w_q > DVD_W'(R_MAX)) ? R_MAX : w_q[MUL_W-1:0];
                            n_state = S_PROD;
                        end
                        default: n_state = S_LOAD;
                    endcase
                end
            end
            S_RD: begin
                w_rd_en = 1'b1;
                n_state = S_DEV;
            end
            S_DEV: begin
                // pixel 'first' sits in the high byte of the store word
                n_ax    = (w_px >= r_mx) ? w_px - r_mx : r_mx - w_px;
                n_ay    = (w_py >= r_my) ? w_py - r_my : r_my - w_py;
                n_state = S_SQX;
            end
            S_SQX: begin
                w_mul_a = MUL_W'(r_ax);
                w_mul_b = MUL_W'(r_ax);
                n_state = S_SQY;
            end
            S_SQY: begin
                n_acc_x = r_acc_x + ACC_W'(w_prod[2*MEAN_W-1:0]);
                w_mul_a = MUL_W'(r_ay);
                w_mul_b = MUL_W'(r_ay);
                n_state = S_XY;
            end
            S_XY: begin
                n_acc_y = r_acc_y + ACC_W'(w_prod[2*MEAN_W-1:0]);
                w_mul_a = MUL_W'(r_ax);
                w_mul_b = MUL_W'(r_ay);
                n_state = S_ACC;
            end
            S_ACC: begin
                n_acc_xy = r_acc_xy + ACC_W'(w_prod[2*MEAN_W-1:0]);
                if (r_idx == ADDR_W'(r_n - 1'b1)) begin
                    n_div_op    = D_SX;
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_RD;
                end
            end
            S_A: begin
                w_mul_a = MUL_W'(r_mx);
                w_mul_b = MUL_W'(r_my);
                n_state = S_B1;
            end
            S_B1: begin
                n_a     = (w_a_full > (NUM_W+1)'(NUM_SAT)) ? NUM_SAT : w_a_full[NUM_W-1:0];
                w_mul_a = MUL_W'(r_mx);
                w_mul_b = MUL_W'(r_mx);
                n_state = S_B2;
            end
            S_B2: begin
                n_b     = w_prod[DVS_W-1:0] + SSIM_C1;
                w_mul_a = MUL_W'(r_my);
                w_mul_b = MUL_W'(r_my);
                n_state = S_B3;
            end
            S_B3: begin
                n_b         = r_b + w_prod[DVS_W-1:0];
                n_c         = (w_c_full > (VAR_W+2)'(NUM_SAT)) ? NUM_SAT : w_c_full[NUM_W-1:0];
                n_d         = DVS_W'(w_d_full);
                n_div_op    = D_R1;
                w_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_PROD: begin
                w_mul_a = r_r1;
                w_mul_b = r_r2;
                n_state = S_OUT;
            end
            S_OUT: begin
                w_mul_a = r_r1;
                w_mul_b = r_r2;
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = (w_s > 20'(ONE_Q16)) ? ONE_Q16 : w_s[SIM_W-1:0];
                    n_sum_x     = '0;
                    n_sum_y     = '0;
                    n_count     = '0;
                    n_state     = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // divider operands come from next-state values so a start can chain
    always_comb begin
        w_div_req.start    = w_div_start;
        w_div_req.dividend = '0;
        w_div_req.divisor  = DVS_W'(n_n);
        case (n_div_op)
            D_MX:    w_div_req.dividend = DVD_W'({n_sum_x, 8'd0});
            D_MY:    w_div_req.dividend = DVD_W'({n_sum_y, 8'd0});
            D_SX: begin
                w_div_req.dividend = DVD_W'(n_acc_x);
                w_div_req.divisor  = DVS_W'(n_n - 1'b1);
            end
            D_SY: begin
                w_div_req.dividend = DVD_W'(n_acc_y);
                w_div_req.divisor  = DVS_W'(n_n - 1'b1);
            end
            D_SXY: begin
                w_div_req.dividend = DVD_W'(n_acc_xy);
                w_div_req.divisor  = DVS_W'(n_n - 1'b1);
            end
            D_R1: begin
                w_div_req.dividend = DVD_W'({n_a, 30'd0});
                w_div_req.divisor  = n_b;
            end
            D_R2: begin
                w_div_req.dividend = DVD_W'({n_c, 30'd0});
                w_div_req.divisor  = n_d;
            end
            default: w_div_req.dividend = '0;
        endcase
    end

    gssim_store #(.DEPTH(DEPTH)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data ({i_s_axis_tdata[7:0], i_s_axis_tdata[15:8]}),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_data)
    );

    gssim_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    gssim_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = 24'(r_out_data);

    a_ready_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !w_div_rsp.busy)
        else $error("divider busy while taking pixels");

    a_frame_end_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_frame_end) |=> !o_s_axis_tready)
        else $error("pixel input still ready after frame end");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[SIM_W-1:0] <= ONE_Q16))
        else $error("similarity above one");

endmodule

// ===== sv/gssim_store.sv =====
module gssim_store #(
    parameter  int unsigned DEPTH  = 65536,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [15:0]       i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [15:0]       o_rd_data
);
    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== sv/gssim_mul.sv =====
module gssim_mul (
    input  logic                          i_clk,
    input  logic [gssim_pkg::MUL_W-1:0]   i_a,
    input  logic [gssim_pkg::MUL_W-1:0]   i_b,
    output logic [2*gssim_pkg::MUL_W-1:0] o_prod
);
    import gssim_pkg::*;

    logic [2*MUL_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;
endmodule

// ===== sv/gssim_div.sv =====
module gssim_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gssim_pkg::t_div_req i_req,
    output gssim_pkg::t_div_rsp o_rsp
);
    import gssim_pkg::*;

    localparam int unsigned CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   w_shift;
    logic [DVS_W:0]   w_diff;

    // restoring divider, one quotient bit per cycle
    assign w_shift = {r_rem, r_q[DVD_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            if (!w_diff[DVS_W]) begin
                r_rem <= w_diff[DVS_W-1:0];
                r_q   <= {r_q[DVD_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[DVS_W-1:0];
                r_q   <= {r_q[DVD_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;
endmodule

// ===== test/tb_global_ssim_image_similarity_top.sv =====
`timescale 1ns / 1ps

class ssim_scoreboard;
    int unsigned width_reg  = 256;
    int unsigned height_reg = 256;
    logic [7:0]  frame_first[$];
    logic [7:0]  frame_second[$];
    longint unsigned sum_first;
    longint unsigned sum_second;
    logic [16:0] expected_sim[$];
    int unsigned errors;

    function int unsigned frame_pixels();
        int unsigned w;
        int unsigned h;
        w = width_reg;
        h = height_reg;
        if (w < 2) w = 2;
        if (w > 256) w = 256;
        if (h < 1) h = 1;
        if (h > 256) h = 256;
        return w * h;
    endfunction

    function logic [16:0] frame_ssim();
        longint unsigned n;
        longint unsigned mx;
        longint unsigned my;
        longint unsigned acc_x;
        longint unsigned acc_y;
        longint unsigned acc_xy;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned sx;
        longint unsigned sy;
        longint unsigned sxy;
        longint unsigned a;
        longint unsigned b;
        longint unsigned c;
        longint unsigned d;
        longint unsigned r1;
        longint unsigned r2;
        longint unsigned s;
        longint dx;
        longint dy;
        n = frame_first.size();
        mx = (sum_first * 256) / n;
        my = (sum_second * 256) / n;
        acc_x = 0;
        acc_y = 0;
        acc_xy = 0;
        foreach (frame_first[i]) begin
            dx = longint'(frame_first[i]) * 256 - longint'(mx);
            dy = longint'(frame_second[i]) * 256 - longint'(my);
            ax = (dx < 0) ? longint'(-dx) : dx;
            ay = (dy < 0) ? longint'(-dy) : dy;
            acc_x += ax * ax;
            acc_y += ay * ay;
            acc_xy += ax * ay;
        end
        sx = acc_x / (n - 1);
        sy = acc_y / (n - 1);
        sxy = acc_xy / (n - 1);
        a = 2 * mx * my + 426148;
        b = mx * mx + my * my + 426148;
        c = 2 * sxy + 3835331;
        d = sx + sy + 3835331;
        if (a > 64'h1_FFFF_FFFF) a = 64'h1_FFFF_FFFF;
        if (c > 64'h1_FFFF_FFFF) c = 64'h1_FFFF_FFFF;
        r1 = (a << 30) / b;
        r2 = (c << 30) / d;
        if (r1 > 64'h8000_0000) r1 = 64'h8000_0000;
        if (r2 > 64'h8000_0000) r2 = 64'h8000_0000;
        s = (r1 * r2) >> 44;
        if (s > 65536) s = 65536;
        return s[16:0];
    endfunction

    function void note_pixel(logic [7:0] p1, logic [7:0] p2);
        frame_first = {frame_first, p1};
        frame_second = {frame_second, p2};
        sum_first += p1;
        sum_second += p2;
        if (frame_first.size() >= frame_pixels()) begin
            expected_sim = {expected_sim, frame_ssim()};
            frame_first.delete();
            frame_second.delete();
            sum_first = 0;
            sum_second = 0;
        end
    endfunction

    function void check_result(logic [16:0] sim);
        logic [16:0] exp_sim;
        if (expected_sim.size() == 0) begin
            $error("similarity: unexpected result %0d", sim);
            errors++;
        end else begin
            exp_sim = expected_sim.pop_front();
            if (sim !== exp_sim) begin
                $error("similarity: expected %0d actual %0d", exp_sim, sim);
                errors++;
            end
        end
    endfunction
endclass

module tb_global_ssim_image_similarity_top;
    import gssim_pkg::*;

    localparam int unsigned STALL_LIMIT = 40000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;  // pixel_first[7:0], pixel_second[15:8]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;       // similarity[16:0], pad
    logic        i_cfg_wr_en = 1'b0;
    logic [0:0]  i_cfg_index = CFG_IDX_WIDTH;
    logic [CFG_W-1:0] i_cfg_data = '0;

    ssim_scoreboard sb = new();
    int unsigned pixels_sent;
    int unsigned results_seen;
    int unsigned quiet_cycles;
    bit          tx_no_gaps;
    bit          rx_no_gaps;

    global_ssim_image_similarity_top uut (.*);

    always #5 i_clk = ~i_clk;

    // the caller drops the write enable after its last write
    task automatic write_reg(logic [0:0] idx, logic [CFG_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx == CFG_IDX_WIDTH) sb.width_reg = 32'(val);
        else sb.height_reg = 32'(val);
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (sb.expected_sim.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        drain_results();
        write_reg(CFG_IDX_WIDTH, w);
        write_reg(CFG_IDX_HEIGHT, h);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_pixel(logic [7:0] p1, logic [7:0] p2);
        int unsigned gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {p2, p1};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_pixel(p1, p2);
        pixels_sent++;
        gap = 0;
        if (!tx_no_gaps && $urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // mode 0 random, 1 identical, 2 constant, 3 inverted, 4 small noise
    task automatic send_frame(int unsigned mode);
        int unsigned n;
        logic [7:0] base1;
        logic [7:0] base2;
        logic [7:0] p1;
        logic [7:0] p2;
        n = sb.frame_pixels() - sb.frame_first.size();
        base1 = 8'($urandom);
        base2 = 8'($urandom);
        repeat (n) begin
            p1 = 8'($urandom);
            p2 = 8'($urandom);
            case (mode)
                1: p2 = p1;
                2: begin
                    p1 = base1;
                    p2 = base2;
                end
                3: p2 = ~p1;
                4: p2 = p1 ^ 8'($urandom_range(0, 7));
                default: ;
            endcase
            send_pixel(p1, p2);
        end
    endtask

    // Sink: random back-pressure (none in no-gap phases), one long hold after the sixth result
    initial begin
        int unsigned hold;
        bit          held;
        hold = 0;
        held = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                sb.check_result(o_m_axis_tdata[16:0]);
                results_seen++;
            end
            if (hold > 0) begin
                hold--;
                i_m_axis_tready <= 1'b0;
            end else if (!held && results_seen == 6) begin
                held = 1;
                hold = 3000;
                i_m_axis_tready <= 1'b0;
            end else if (rx_no_gaps) begin
                i_m_axis_tready <= 1'b1;
            end else if ($urandom_range(0, 49) == 0) begin
                hold = $urandom_range(20, 200);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int unsigned pick;
        pixels_sent = 0;
        results_seen = 0;
        quiet_cycles = 0;
        tx_no_gaps = 0;
        rx_no_gaps = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // smallest frame: extremes, constant and inverted images
        set_size(9'd2, 9'd1);
        send_pixel(8'd0, 8'd255);
        send_pixel(8'd255, 8'd0);
        send_pixel(8'd255, 8'd255);
        send_pixel(8'd255, 8'd255);
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd0, 8'd255);
        send_pixel(8'd0, 8'd255);
        set_size(9'd3, 9'd2);
        send_frame(1);
        // width and height below range clamp to 2x1
        set_size(9'd0, 9'd0);
        send_frame(0);
        set_size(9'd1, 9'd1);
        send_frame(3);

        while (pixels_sent < 1500) begin
            pick = $urandom_range(0, 19);
            case (pick)
                0: set_size(9'd256, 9'd1);
                1: set_size(9'h1FF, 9'd1);
                2: set_size(9'd2, 9'd256);
                3: set_size(9'd0, 9'h1FF);
                default: set_size(9'($urandom_range(2, 12)), 9'($urandom_range(1, 6)));
            endcase
            tx_no_gaps = ($urandom_range(0, 4) == 0);
            rx_no_gaps = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 4)) send_frame($urandom_range(0, 4));
        end

        drain_results();
        repeat (100) @(posedge i_clk);
        if (sb.expected_sim.size() != 0) begin
            $error("similarity: %0d results never arrived", sb.expected_sim.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== files.f =====
sv/gssim_pkg.sv
sv/gssim_store.sv
sv/gssim_mul.sv
sv/gssim_div.sv
sv/global_ssim_image_similarity_top.sv
test/tb_global_ssim_image_similarity_top.sv
